// ----- src/usbseg_pkg.sv -----
// Shared types and constants for the USB endpoint transfer segmenter.
// Holds the endpoint table entry layout, the action codes and the register indexes.
// No dependencies.
`timescale 1ns / 1ps

package usbseg_pkg;

	localparam int NUM_EP = 16;
	localparam int EP_IDX_W = $clog2(2 * NUM_EP);

	localparam int ADDR_W = 32;
	localparam int TLEN_W = 16;
	localparam int REM_W = 17;
	localparam int PLEN_W = 11;
	localparam int CMPS_W = 7;
	localparam int DMPS_W = 11;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 11;

	localparam logic [CMPS_W-1:0] CTRL_MPS_MIN = CMPS_W'(8);
	localparam logic [CMPS_W-1:0] CTRL_MPS_MAX = CMPS_W'(64);
	localparam logic [DMPS_W-1:0] DATA_MPS_MIN = DMPS_W'(8);
	localparam logic [DMPS_W-1:0] DATA_MPS_MAX = DMPS_W'(1024);
	localparam logic [CMPS_W-1:0] CTRL_MPS_RST = CMPS_W'(64);
	localparam logic [DMPS_W-1:0] DATA_MPS_RST = DMPS_W'(64);

	typedef enum logic [1:0] {
		ACT_DATA   = 2'd0,
		ACT_ZLP    = 2'd1,
		ACT_STATUS = 2'd2,
		ACT_DONE   = 2'd3
	} act_t;

	typedef enum logic {
		REQ_ARM   = 1'b0,
		REQ_STAGE = 1'b1
	} req_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CTRL_MPS = 1'b0,
		CFG_DATA_MPS = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic                    busy;
		logic [ADDR_W-1:0]       addr;
		logic signed [REM_W-1:0] rem;
	} ep_entry_t;

	typedef struct packed {
		logic                 we;
		logic [EP_IDX_W-1:0]  idx;
		ep_entry_t            entry;
	} ep_upd_t;

	typedef struct packed {
		logic              req_type;
		logic              dir_in;
		logic [3:0]        ep_number;
		logic [ADDR_W-1:0] buffer_address;
		logic [TLEN_W-1:0] transfer_length;
	} item_t;

	typedef struct packed {
		act_t              action;
		logic              act_dir_in;
		logic [3:0]        act_ep;
		logic [ADDR_W-1:0] packet_address;
		logic [PLEN_W-1:0] packet_length;
	} result_t;

endpackage

// ----- src/usbseg_ep_table.sv -----
// Endpoint state table: busy flag, next buffer address and remaining count per endpoint
// and direction. One combinational read port, one write port. Depends on usbseg_pkg.
`timescale 1ns / 1ps

module usbseg_ep_table (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [usbseg_pkg::EP_IDX_W-1:0] rd_idx,
	output usbseg_pkg::ep_entry_t          rd_entry,
	input  usbseg_pkg::ep_upd_t            upd
);
	import usbseg_pkg::*;

	localparam int DEPTH = 2 * NUM_EP;

	logic [DEPTH-1:0]        busy_q;
	logic [ADDR_W-1:0]       addr_q [DEPTH];
	logic signed [REM_W-1:0] rem_q [DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
		end else if (upd.we) begin
			busy_q[upd.idx] <= upd.entry.busy;
		end
	end

	// Address and count are only read while busy, and arming writes both.
	always_ff @(posedge clk) begin
		if (upd.we) begin
			addr_q[upd.idx] <= upd.entry.addr;
			rem_q[upd.idx] <= upd.entry.rem;
		end
	end

	always_comb begin
		rd_entry.busy = busy_q[rd_idx];
		rd_entry.addr = addr_q[rd_idx];
		rd_entry.rem = rem_q[rd_idx];
	end

endmodule

// ----- src/usbseg_stage.sv -----
// Stage step logic: arms an entry when asked, then picks the next packet, zero-length
// packet, status stage or completion notice and the entry update. Depends on usbseg_pkg.
`timescale 1ns / 1ps

module usbseg_stage (
	input  usbseg_pkg::item_t                 item,
	input  usbseg_pkg::ep_entry_t             rd_entry,
	input  logic [usbseg_pkg::CMPS_W-1:0]     ctrl_max_packet,
	input  logic [usbseg_pkg::DMPS_W-1:0]     data_max_packet,
	output logic [usbseg_pkg::EP_IDX_W-1:0]   idx,
	output logic                              has_result,
	output usbseg_pkg::result_t               result,
	output usbseg_pkg::ep_upd_t               upd_raw
);
	import usbseg_pkg::*;

	logic                    ep_ok;
	logic                    ep_zero;
	logic                    arm;
	ep_entry_t               cur;
	logic [CMPS_W-1:0]       ctrl_cl;
	logic [DMPS_W-1:0]       data_cl;
	logic [PLEN_W-1:0]       mps;
	logic [PLEN_W-1:0]       len;
	logic signed [REM_W-1:0] mps_s;
	logic signed [REM_W-1:0] rem_next;

	assign ep_ok = {1'b0, item.ep_number} < 5'(NUM_EP);
	assign ep_zero = (item.ep_number == 4'd0);
	assign arm = (item.req_type == REQ_ARM);
	assign idx = item.dir_in ? EP_IDX_W'(NUM_EP) + EP_IDX_W'(item.ep_number)
		: EP_IDX_W'(item.ep_number);

	always_comb begin
		if (arm) begin
			cur.busy = 1'b1;
			cur.addr = item.buffer_address;
			cur.rem = (item.transfer_length != '0) ? $signed({1'b0, item.transfer_length})
				: -REM_W'(1);
		end else begin
			cur = rd_entry;
		end
	end

	always_comb begin
		ctrl_cl = ctrl_max_packet;
		if (ctrl_max_packet < CTRL_MPS_MIN) ctrl_cl = CTRL_MPS_MIN;
		if (ctrl_max_packet > CTRL_MPS_MAX) ctrl_cl = CTRL_MPS_MAX;
		data_cl = data_max_packet;
		if (data_max_packet < DATA_MPS_MIN) data_cl = DATA_MPS_MIN;
		if (data_max_packet > DATA_MPS_MAX) data_cl = DATA_MPS_MAX;
		mps = ep_zero ? PLEN_W'(ctrl_cl) : PLEN_W'(data_cl);
	end

	assign mps_s = $signed({(REM_W - PLEN_W)'(0), mps});
	assign len = (cur.rem > mps_s) ? mps : cur.rem[PLEN_W-1:0];
	assign rem_next = cur.rem - $signed({(REM_W - PLEN_W)'(0), len});

	always_comb begin
		has_result = 1'b1;
		result.action = ACT_DONE;
		result.act_dir_in = item.dir_in;
		result.act_ep = item.ep_number;
		result.packet_address = '0;
		result.packet_length = '0;
		upd_raw.we = ep_ok;
		upd_raw.idx = idx;
		upd_raw.entry = cur;

		priority if (!cur.busy) begin
			has_result = !ep_zero;
		end else if (item.dir_in && cur.rem < 0) begin
			upd_raw.entry.rem = '0;
			result.action = ACT_ZLP;
		end else if (cur.rem <= 0) begin
			upd_raw.entry.busy = 1'b0;
			if (ep_zero) begin
				result.action = ACT_STATUS;
				result.act_dir_in = !item.dir_in;
			end
		end else begin
			result.action = ACT_DATA;
			result.packet_address = cur.addr;
			result.packet_length = len;
			upd_raw.entry.addr = cur.addr + ADDR_W'(len);
			upd_raw.entry.rem = rem_next;
			// A control IN transfer ending on a full packet owes a zero-length packet.
			if (item.dir_in && ep_zero && rem_next == '0 && len == mps) begin
				upd_raw.entry.rem = -REM_W'(1);
			end
		end

		if (!ep_ok) begin
			has_result = 1'b0;
		end
	end

endmodule

// ----- src/usb_endpoint_transfer_segmenter_core.sv -----
// Top level of the USB endpoint transfer segmenter: request register, endpoint table,
// stage logic, result register and max-packet registers. Depends on usbseg_pkg.
//
// Channel   Handshake             Payload
// in        in_valid / in_ready   req_type, dir_in, ep_number, buffer_address, transfer_length
// out       out_valid / out_ready action, act_dir_in, act_ep, packet_address, packet_length
// cfg       cfg_write             cfg_index, cfg_data
//
// An accepted request waits in the request register; its result is then loaded into the
// result register, which holds it until out_ready takes it.
// One request can be accepted every cycle while no stalled result holds it back; the
// endpoint entry is read and written back in the same cycle, so a following request on the
// same endpoint sees the update. A stalled result holds the request register, which then
// holds in_ready low. Reset clears all busy flags and sets both max-packet sizes to 64.
`timescale 1ns / 1ps

module usb_endpoint_transfer_segmenter_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                req_type,
	input  logic                                dir_in,
	input  logic [3:0]                          ep_number,
	input  logic [usbseg_pkg::ADDR_W-1:0]       buffer_address,
	input  logic [usbseg_pkg::TLEN_W-1:0]       transfer_length,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [1:0]                          action,
	output logic                                act_dir_in,
	output logic [3:0]                          act_ep,
	output logic [usbseg_pkg::ADDR_W-1:0]       packet_address,
	output logic [usbseg_pkg::PLEN_W-1:0]       packet_length,
	input  logic                                cfg_write,
	input  logic [usbseg_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [usbseg_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import usbseg_pkg::*;

	logic                 v_s1;
	item_t                item_s1;
	logic                 v_s2;
	result_t              res_s2;
	logic [CMPS_W-1:0]    ctrl_mps_q;
	logic [DMPS_W-1:0]    data_mps_q;
	logic [EP_IDX_W-1:0]  idx;
	ep_entry_t            rd_entry;
	logic                 has_result;
	result_t              result;
	ep_upd_t              upd_raw;
	ep_upd_t              upd;
	logic                 out_free;
	logic                 advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_mps_q <= CTRL_MPS_RST;
			data_mps_q <= DATA_MPS_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_CTRL_MPS: ctrl_mps_q <= cfg_data[CMPS_W-1:0];
				CFG_DATA_MPS: data_mps_q <= cfg_data[DMPS_W-1:0];
				default: ;
			endcase
		end
	end

	assign out_free = !v_s2 || out_ready;
	assign advance = v_s1 && (out_free || !has_result);
	assign in_ready = !v_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.req_type <= req_type;
			item_s1.dir_in <= dir_in;
			item_s1.ep_number <= ep_number;
			item_s1.buffer_address <= buffer_address;
			item_s1.transfer_length <= transfer_length;
		end
	end

	usbseg_ep_table u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_idx   (idx),
		.rd_entry (rd_entry),
		.upd      (upd)
	);

	usbseg_stage u_stage (
		.item            (item_s1),
		.rd_entry        (rd_entry),
		.ctrl_max_packet (ctrl_mps_q),
		.data_max_packet (data_mps_q),
		.idx             (idx),
		.has_result      (has_result),
		.result          (result),
		.upd_raw         (upd_raw)
	);

	always_comb begin
		upd = upd_raw;
		upd.we = upd_raw.we && advance;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (out_free) begin
			v_s2 <= advance && has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && advance && has_result) begin
			res_s2 <= result;
		end
	end

	assign out_valid = v_s2;
	assign action = res_s2.action;
	assign act_dir_in = res_s2.act_dir_in;
	assign act_ep = res_s2.act_ep;
	assign packet_address = res_s2.packet_address;
	assign packet_length = res_s2.packet_length;

	a_empty_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && action != ACT_DATA |-> packet_length == '0 && packet_address == '0)
		else $error("empty action carries packet data");

	a_data_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && action == ACT_DATA |-> packet_length != '0 && packet_length <= DATA_MPS_MAX)
		else $error("data packet length out of range");

	a_status_ep0: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && action == ACT_STATUS |-> act_ep == 4'd0)
		else $error("status stage off endpoint zero");

	a_ctrl_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && action == ACT_DATA && act_ep == 4'd0 |-> packet_length <= PLEN_W'(CTRL_MPS_MAX))
		else $error("control packet exceeds limit");

	a_no_write_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		upd.we |-> v_s1 && (out_free || !has_result))
		else $error("endpoint entry written by a stalled request");

endmodule

// ----- dv/usb_endpoint_transfer_segmenter_checker.sv -----
// Checker for the USB endpoint transfer segmenter: watches the request, result and register
// ports, keeps its own endpoint table to predict each result, and counts mismatches.
// Depends on usbseg_pkg.
`timescale 1ns / 1ps

module usb_endpoint_transfer_segmenter_checker
	import usbseg_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic                  req_type,
	input  logic                  dir_in,
	input  logic [3:0]            ep_number,
	input  logic [ADDR_W-1:0]     buffer_address,
	input  logic [TLEN_W-1:0]     transfer_length,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic [1:0]            action,
	input  logic                  act_dir_in,
	input  logic [3:0]            act_ep,
	input  logic [ADDR_W-1:0]     packet_address,
	input  logic [PLEN_W-1:0]     packet_length,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  end_check,
	output int                    fail_count,
	output int                    pending
);

	logic              ep_busy_tbl [2*NUM_EP];
	logic [ADDR_W-1:0] ep_addr_tbl [2*NUM_EP];
	int                ep_rem_tbl [2*NUM_EP];
	logic [CMPS_W-1:0] ctrl_mps_reg;
	logic [DMPS_W-1:0] data_mps_reg;
	result_t           expected_q [$];
	int                n_requests = 0;
	int                n_cfg_writes = 0;
	int                n_actions [4] = '{0, 0, 0, 0};
	bit                end_done = 1'b0;

	initial begin
		fail_count = 0;
		pending = 0;
	end

	task automatic report_mismatch(input string what);
		$display("[%0t] MISMATCH: %s", $time, what);
		fail_count++;
	endtask

	function automatic int packet_limit(input logic [3:0] ep);
		int lim;
		if (ep == 0) begin
			lim = int'(ctrl_mps_reg);
			if (lim < int'(CTRL_MPS_MIN)) lim = int'(CTRL_MPS_MIN);
			if (lim > int'(CTRL_MPS_MAX)) lim = int'(CTRL_MPS_MAX);
		end else begin
			lim = int'(data_mps_reg);
			if (lim < int'(DATA_MPS_MIN)) lim = int'(DATA_MPS_MIN);
			if (lim > int'(DATA_MPS_MAX)) lim = int'(DATA_MPS_MAX);
		end
		return lim;
	endfunction

	task automatic segment_request(input logic req, input logic din, input logic [3:0] ep,
			input logic [ADDR_W-1:0] addr, input logic [TLEN_W-1:0] tlen);
		int idx;
		int rem;
		int mps;
		int plen;
		result_t res;
		idx = int'({din, ep});
		if (req == REQ_ARM) begin
			ep_busy_tbl[idx] = 1'b1;
			ep_addr_tbl[idx] = addr;
			ep_rem_tbl[idx] = (tlen != 0) ? int'(tlen) : -1;
		end
		rem = ep_rem_tbl[idx];
		mps = packet_limit(ep);
		res.action = ACT_DONE;
		res.act_dir_in = din;
		res.act_ep = ep;
		res.packet_address = '0;
		res.packet_length = '0;
		if (!ep_busy_tbl[idx]) begin
			// An idle control endpoint gives no result at all.
			if (ep == 0) return;
		end else if (din && rem < 0) begin
			ep_rem_tbl[idx] = 0;
			res.action = ACT_ZLP;
		end else if (rem <= 0) begin
			ep_busy_tbl[idx] = 1'b0;
			if (ep == 0) begin
				res.action = ACT_STATUS;
				res.act_dir_in = !din;
			end
		end else begin
			plen = (rem > mps) ? mps : rem;
			res.action = ACT_DATA;
			res.packet_address = ep_addr_tbl[idx];
			res.packet_length = PLEN_W'(plen);
			ep_addr_tbl[idx] = ep_addr_tbl[idx] + ADDR_W'(plen);
			rem = rem - plen;
			// A control IN transfer that ends on a full packet still owes a zero-length one.
			if (din && ep == 0 && rem == 0 && plen == mps) rem = -1;
			ep_rem_tbl[idx] = rem;
		end
		expected_q.push_back(res);
	endtask

	task automatic compare_result();
		result_t want;
		n_actions[action]++;
		if (expected_q.size() == 0) begin
			report_mismatch($sformatf("unexpected result action %0d ep %0d dir_in %0d",
				action, act_ep, act_dir_in));
			return;
		end
		want = expected_q.pop_front();
		if (action !== want.action)
			report_mismatch($sformatf("action %0d, expected %0d", action, want.action));
		if (act_dir_in !== want.act_dir_in)
			report_mismatch($sformatf("act_dir_in %0d, expected %0d", act_dir_in,
				want.act_dir_in));
		if (act_ep !== want.act_ep)
			report_mismatch($sformatf("act_ep %0d, expected %0d", act_ep, want.act_ep));
		if (packet_address !== want.packet_address)
			report_mismatch($sformatf("packet_address %h, expected %h", packet_address,
				want.packet_address));
		if (packet_length !== want.packet_length)
			report_mismatch($sformatf("packet_length %0d, expected %0d", packet_length,
				want.packet_length));
	endtask

	task automatic close_out();
		result_t want;
		while (expected_q.size() != 0) begin
			want = expected_q.pop_front();
			report_mismatch($sformatf("missing result action %0d ep %0d dir_in %0d",
				want.action, want.act_ep, want.act_dir_in));
		end
		$display("Covered %0d requests and %0d results over %0d register writes.",
			n_requests, n_actions[0] + n_actions[1] + n_actions[2] + n_actions[3], n_cfg_writes);
		$display("Results by kind: %0d data, %0d zero-length, %0d status, %0d completion.",
			n_actions[ACT_DATA], n_actions[ACT_ZLP], n_actions[ACT_STATUS], n_actions[ACT_DONE]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (ep_busy_tbl[i]) ep_busy_tbl[i] = 1'b0;
			ctrl_mps_reg = CTRL_MPS_RST;
			data_mps_reg = DATA_MPS_RST;
			expected_q.delete();
			pending = 0;
		end else begin
			if (cfg_write) begin
				n_cfg_writes++;
				if (cfg_index == CFG_CTRL_MPS) ctrl_mps_reg = cfg_data[CMPS_W-1:0];
				else data_mps_reg = cfg_data[DMPS_W-1:0];
			end
			if (out_valid && out_ready) compare_result();
			if (in_valid && in_ready) begin
				n_requests++;
				segment_request(req_type, dir_in, ep_number, buffer_address, transfer_length);
			end
			if (end_check && !end_done) begin
				close_out();
				end_done = 1'b1;
			end
			pending = expected_q.size();
		end
	end

endmodule

// ----- dv/usb_endpoint_transfer_segmenter_core_tb.sv -----
// Testbench top for the USB endpoint transfer segmenter: clock, reset, request and register
// stimulus, result back-pressure and the final verdict.
// Depends on usbseg_pkg, the segmenter core and usb_endpoint_transfer_segmenter_checker.
`timescale 1ns / 1ps

module usb_endpoint_transfer_segmenter_core_tb;
	import usbseg_pkg::*;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  req_type = 1'b0;
	logic                  dir_in = 1'b0;
	logic [3:0]            ep_number = '0;
	logic [ADDR_W-1:0]     buffer_address = '0;
	logic [TLEN_W-1:0]     transfer_length = '0;
	logic                  out_ready = 1'b0;
	logic                  cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  end_check = 1'b0;
	logic                  in_ready;
	logic                  out_valid;
	logic [1:0]            action;
	logic                  act_dir_in;
	logic [3:0]            act_ep;
	logic [ADDR_W-1:0]     packet_address;
	logic [PLEN_W-1:0]     packet_length;
	int                    fail_count;
	int                    pending;
	int                    tx_idle_pct = 0;
	int                    rx_idle_pct = 0;
	int                    sent_count = 0;
	int                    ctrl_mps_now = 64;
	int                    data_mps_now = 64;

	usb_endpoint_transfer_segmenter_core dut (.*);

	usb_endpoint_transfer_segmenter_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("usb_endpoint_transfer_segmenter_core test failed");
		$finish;
	end

	always @(negedge clk) out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);

	task automatic send_request(input req_t req, input logic din, input logic [3:0] ep,
			input logic [ADDR_W-1:0] addr, input logic [TLEN_W-1:0] tlen);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= req;
		dir_in <= din;
		ep_number <= ep;
		buffer_address <= addr;
		transfer_length <= tlen;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent_count++;
		@(negedge clk);
	endtask

	task automatic drain_wait();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_mps(input logic [CFG_DATA_W-1:0] ctrl, input logic [CFG_DATA_W-1:0] data);
		drain_wait();
		cfg_write <= 1'b1;
		cfg_index <= CFG_CTRL_MPS;
		cfg_data <= ctrl;
		@(negedge clk);
		cfg_index <= CFG_DATA_MPS;
		cfg_data <= data;
		@(negedge clk);
		cfg_write <= 1'b0;
		@(negedge clk);
		ctrl_mps_now = ctrl[CMPS_W-1:0] < 8 ? 8 : ctrl[CMPS_W-1:0] > 64 ? 64 : ctrl[CMPS_W-1:0];
		data_mps_now = data < 8 ? 8 : data > 1024 ? 1024 : data;
	endtask

	task automatic send_noise();
		send_request(req_t'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
			4'($urandom_range(0, 15)), $urandom, TLEN_W'($urandom));
	endtask

	task automatic directed_requests();
		// Control IN of zero length, then of exactly one full packet.
		send_request(REQ_ARM, 1'b1, 4'd0, 32'h0000_1000, 16'd0);
		send_request(REQ_STAGE, 1'b1, 4'd0, 32'h0, 16'd0);
		send_request(REQ_ARM, 1'b1, 4'd0, 32'h0000_2000, 16'd64);
		send_request(REQ_STAGE, 1'b1, 4'd0, 32'h0, 16'd0);
		send_request(REQ_STAGE, 1'b1, 4'd0, 32'h0, 16'd0);
		// Control OUT: zero length completes at once, a longer one takes two packets.
		send_request(REQ_ARM, 1'b0, 4'd0, 32'h0000_3000, 16'd0);
		send_request(REQ_ARM, 1'b0, 4'd0, 32'h0000_4000, 16'd100);
		send_request(REQ_STAGE, 1'b0, 4'd0, 32'h0, 16'd0);
		send_request(REQ_STAGE, 1'b0, 4'd0, 32'h0, 16'd0);
		// Stage requests on idle endpoints.
		send_request(REQ_STAGE, 1'b1, 4'd0, 32'hFFFF_FFFF, 16'hFFFF);
		send_request(REQ_STAGE, 1'b0, 4'd0, 32'hFFFF_FFFF, 16'hFFFF);
		send_request(REQ_STAGE, 1'b1, 4'd15, 32'h0, 16'd0);
		// Longest transfer from the top of the address space, then re-armed while busy.
		send_request(REQ_ARM, 1'b1, 4'd15, 32'hFFFF_FFF0, 16'hFFFF);
		send_request(REQ_STAGE, 1'b1, 4'd15, 32'h0, 16'd0);
		send_request(REQ_ARM, 1'b1, 4'd15, 32'h0, 16'd1);
		send_request(REQ_STAGE, 1'b1, 4'd15, 32'h0, 16'd0);
		// Data endpoints ending on a full packet send no zero-length packet; a zero-length IN one does.
		send_request(REQ_ARM, 1'b0, 4'd1, 32'h0001_0000, 16'd64);
		send_request(REQ_STAGE, 1'b0, 4'd1, 32'h0, 16'd0);
		send_request(REQ_ARM, 1'b1, 4'd1, 32'h0002_0000, 16'd128);
		send_request(REQ_STAGE, 1'b1, 4'd1, 32'h0, 16'd0);
		send_request(REQ_STAGE, 1'b1, 4'd1, 32'h0, 16'd0);
		send_request(REQ_ARM, 1'b1, 4'd7, 32'h0003_0000, 16'd0);
		send_request(REQ_STAGE, 1'b1, 4'd7, 32'h0, 16'd0);
	endtask

	task automatic run_transfers(input int count);
		int target;
		int n_stages;
		int mps;
		int cls;
		int i;
		logic din;
		logic [3:0] ep;
		logic [TLEN_W-1:0] tlen;
		logic [ADDR_W-1:0] addr;
		target = sent_count + count;
		while (sent_count < target) begin
			if ($urandom_range(0, 99) < 12) begin
				send_noise();
			end else begin
				din = 1'($urandom_range(0, 1));
				ep = ($urandom_range(0, 9) < 3) ? 4'd0 : 4'($urandom_range(1, 15));
				mps = (ep == 0) ? ctrl_mps_now : data_mps_now;
				cls = $urandom_range(0, 9);
				case (cls)
					0: tlen = '0;
					1: tlen = TLEN_W'(mps * $urandom_range(1, 3));
					2: tlen = TLEN_W'(mps * $urandom_range(1, 3) + 1);
					3: tlen = TLEN_W'(mps * $urandom_range(1, 3) - 1);
					9: tlen = TLEN_W'($urandom);
					default: tlen = TLEN_W'($urandom_range(1, 3 * mps));
				endcase
				n_stages = (cls == 9) ? $urandom_range(0, 4) : int'(tlen) / mps + 2;
				if ($urandom_range(0, 9) == 0) n_stages = $urandom_range(0, n_stages);
				addr = ($urandom_range(0, 7) == 0) ? (32'hFFFF_FF00 | $urandom_range(0, 255))
					: $urandom;
				send_request(REQ_ARM, din, ep, addr, tlen);
				for (i = 0; i < n_stages; i++) begin
					if ($urandom_range(0, 9) == 0) send_noise();
					send_request(REQ_STAGE, din, ep, $urandom, TLEN_W'($urandom));
				end
			end
		end
	endtask

	initial begin
		int ph;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		tx_idle_pct = 30;
		rx_idle_pct = 66;
		directed_requests();
		for (ph = 0; ph < 6; ph++) begin
			tx_idle_pct = (ph < 2) ? 30 : (ph < 4) ? 66 : 0;
			rx_idle_pct = (ph < 2) ? 66 : (ph < 4) ? 30 : 0;
			case (ph)
				0: write_mps(11'd8, 11'd8);
				1: write_mps(11'h7FF, 11'd0);
				2: write_mps(11'd64, 11'd1024);
				3: write_mps(11'($urandom_range(8, 64)), 11'($urandom_range(8, 1024)));
				4: write_mps(11'd0, 11'h7FF);
				default: write_mps(11'($urandom_range(0, 127)), 11'($urandom_range(0, 2047)));
			endcase
			run_transfers(260);
		end
		drain_wait();
		end_check <= 1'b1;
		repeat (2) @(negedge clk);
		if (fail_count == 0) begin
			$display("usb_endpoint_transfer_segmenter_core test passed");
		end else begin
			$display("usb_endpoint_transfer_segmenter_core test failed");
		end
		$finish;
	end

endmodule
